### rtl/core/spq_pkg.sv
package spq_pkg;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_PEEK   = 2'd2
  } kind_e;

  // Per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic shift_in;   // insert: open a gap at the insertion point
    logic shift_out;  // remove: every cell takes its successor's entry
  } cell_ctrl_t;

endpackage

### rtl/core/spq_if.sv
interface spq_req_if #(
  parameter int unsigned PRIORITY_WIDTH = 8,
  parameter int unsigned PAYLOAD_WIDTH  = 16
);
  logic                      valid;
  logic                      ready;
  logic [1:0]                kind;
  logic [PRIORITY_WIDTH-1:0] priority_req;
  logic [PAYLOAD_WIDTH-1:0]  payload;

  modport source (output valid, kind, priority_req, payload, input ready);
  modport sink   (input valid, kind, priority_req, payload, output ready);
endinterface

interface spq_rsp_if #(
  parameter int unsigned PAYLOAD_WIDTH = 16
);
  logic                     valid;
  logic                     ready;
  logic [PAYLOAD_WIDTH-1:0] data_out;
  logic                     empty_res;
  logic                     dropped;

  modport source (output valid, data_out, empty_res, dropped, input ready);
  modport sink   (input valid, data_out, empty_res, dropped, output ready);
endinterface

### rtl/core/spq_cell.sv
module spq_cell
  import spq_pkg::*;
#(
  parameter int unsigned PRIORITY_WIDTH = 8,
  parameter int unsigned PAYLOAD_WIDTH  = 16
) (
  input  logic                      clk_i,
  input  cell_ctrl_t                ctrl_i,
  input  logic                      occupied_i,
  input  logic [PRIORITY_WIDTH-1:0] new_prio_i,
  input  logic [PAYLOAD_WIDTH-1:0]  new_payload_i,
  input  logic                      prev_place_i,
  input  logic [PRIORITY_WIDTH-1:0] prev_prio_i,
  input  logic [PAYLOAD_WIDTH-1:0]  prev_payload_i,
  input  logic [PRIORITY_WIDTH-1:0] next_prio_i,
  input  logic [PAYLOAD_WIDTH-1:0]  next_payload_i,
  output logic                      place_o,
  output logic [PRIORITY_WIDTH-1:0] prio_o,
  output logic [PAYLOAD_WIDTH-1:0]  payload_o
);

  logic [PRIORITY_WIDTH-1:0] prio_q, prio_d;
  logic [PAYLOAD_WIDTH-1:0]  payload_q, payload_d;

  // New entry belongs at or before this slot (equal priorities stay ahead)
  assign place_o = !occupied_i || (prio_q > new_prio_i);

  always_comb begin
    prio_d    = prio_q;
    payload_d = payload_q;
    if (ctrl_i.shift_in && place_o) begin
      if (prev_place_i) begin
        prio_d    = prev_prio_i;
        payload_d = prev_payload_i;
      end else begin
        prio_d    = new_prio_i;
        payload_d = new_payload_i;
      end
    end else if (ctrl_i.shift_out) begin
      prio_d    = next_prio_i;
      payload_d = next_payload_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prio_q    <= prio_d;
    payload_q <= payload_d;
  end

  assign prio_o    = prio_q;
  assign payload_o = payload_q;

endmodule

### rtl/core/sorted_priority_queue_unit.sv
// Sorted priority queue of DEPTH entries held in a chain of cells, smallest
// priority at the front and equal priorities in arrival order. On a request
// (insert, remove or peek) all cells compare the new priority in parallel
// and a successful insert or remove shifts the chain by one place, so a
// request can be accepted on every clock while the result register is free
// or being emptied. The response (front payload, empty flag, full-drop flag)
// is registered for the cycle after acceptance and held until taken.
module sorted_priority_queue_unit
  import spq_pkg::*;
#(
  parameter int unsigned DEPTH          = 16,
  parameter int unsigned PRIORITY_WIDTH = 8,
  parameter int unsigned PAYLOAD_WIDTH  = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  spq_req_if.sink   req_i,
  spq_rsp_if.source rsp_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [CntW-1:0] count_q, count_d;
  logic            rsp_valid_q;
  logic [PAYLOAD_WIDTH-1:0] data_q, data_d;
  logic            empty_q, empty_d;
  logic            dropped_q, dropped_d;

  logic       accept;
  logic       is_empty, is_full;
  cell_ctrl_t ctrl;

  logic [DEPTH-1:0]                     occupied;
  logic [DEPTH-1:0]                     place;
  logic [DEPTH-1:0][PRIORITY_WIDTH-1:0] prio;
  logic [DEPTH-1:0][PAYLOAD_WIDTH-1:0]  pay;

  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;
  assign is_empty    = (count_q == '0);
  assign is_full     = (count_q == CntW'(DEPTH));

  always_comb begin
    ctrl      = '0;
    count_d   = count_q;
    data_d    = '0;
    empty_d   = 1'b0;
    dropped_d = 1'b0;
    if (accept) begin
      case (req_i.kind)
        KIND_INSERT: begin
          if (is_full) begin
            dropped_d = 1'b1;
          end else begin
            ctrl.shift_in = 1'b1;
            count_d       = count_q + CntW'(1);
          end
        end
        KIND_REMOVE, KIND_PEEK: begin
          if (is_empty) begin
            empty_d = 1'b1;
          end else begin
            data_d = pay[0];
            if (req_i.kind == KIND_REMOVE) begin
              ctrl.shift_out = 1'b1;
              count_d        = count_q - CntW'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic                      prev_place;
    logic [PRIORITY_WIDTH-1:0] prev_prio, next_prio;
    logic [PAYLOAD_WIDTH-1:0]  prev_pay, next_pay;

    assign occupied[g] = (count_q > CntW'(g));

    if (g == 0) begin : g_head
      assign prev_place = 1'b0;
      assign prev_prio  = req_i.priority_req;
      assign prev_pay   = req_i.payload;
    end else begin : g_body
      assign prev_place = place[g-1];
      assign prev_prio  = prio[g-1];
      assign prev_pay   = pay[g-1];
    end

    // Tail takes its own entry on a remove; it falls out of the count anyway
    if (g == DEPTH - 1) begin : g_tail
      assign next_prio = prio[g];
      assign next_pay  = pay[g];
    end else begin : g_mid
      assign next_prio = prio[g+1];
      assign next_pay  = pay[g+1];
    end

    spq_cell #(
      .PRIORITY_WIDTH(PRIORITY_WIDTH),
      .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
    ) u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .occupied_i    (occupied[g]),
      .new_prio_i    (req_i.priority_req),
      .new_payload_i (req_i.payload),
      .prev_place_i  (prev_place),
      .prev_prio_i   (prev_prio),
      .prev_payload_i(prev_pay),
      .next_prio_i   (next_prio),
      .next_payload_i(next_pay),
      .place_o       (place[g]),
      .prio_o        (prio[g]),
      .payload_o     (pay[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q    <= data_d;
      empty_q   <= empty_d;
      dropped_q <= dropped_d;
    end
  end

  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.data_out  = data_q;
  assign rsp_o.empty_res = empty_q;
  assign rsp_o.dropped   = dropped_q;

endmodule
